[hw/rtl/gich_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gich_pkg
// Register offsets, bit positions and stream widths for the virtual
// interface control register block.
// ----------------------------------------------------------------------------
package gich_pkg;

    // Register frame offsets
    localparam logic [11:0] OFF_HCR    = 12'h000;
    localparam logic [11:0] OFF_VTR    = 12'h004;
    localparam logic [11:0] OFF_VMCR   = 12'h008;
    localparam logic [11:0] OFF_MISR   = 12'h010;
    localparam logic [11:0] OFF_EISR0  = 12'h020;
    localparam logic [11:0] OFF_EISR1  = 12'h024;
    localparam logic [11:0] OFF_ELRSR0 = 12'h030;
    localparam logic [11:0] OFF_ELRSR1 = 12'h034;
    localparam logic [11:0] OFF_APR    = 12'h0F0;
    // list registers live in the 0x100 page
    localparam logic [3:0]  LR_PAGE    = 4'h1;

    // Bus operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // List register bit positions
    localparam int LR_STATE_HI = 29;
    localparam int LR_STATE_LO = 28;
    localparam int LR_HW_BIT   = 31;
    localparam int LR_EOI_BIT  = 19;

    // HCR bit positions
    localparam int HCR_EN_BIT  = 0;
    localparam int HCR_UIE_BIT = 1;

    // VTR fixed fields: PRIbits in [31:29], PREbits in [28:26]
    localparam logic [2:0]  VTR_PRI_BITS = 3'b100;
    localparam logic [2:0]  VTR_PRE_BITS = 3'b100;
    localparam int          VTR_CNT_W    = 6;

    // Status map width (EISR0/1, ELRSR0/1)
    localparam int STATUS_W = 64;

    // Field widths
    localparam int LR_COUNT_W = 7;
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;

    // Stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam logic [LR_COUNT_W-1:0] LR_COUNT_RST = 7'd4;

endpackage

[hw/rtl/gic_virtual_interface_control_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_virtual_interface_control_regs
// Virtual interface control register frame (HCR, VTR, VMCR, MISR, EISR,
// ELRSR, APR and the list registers) behind a stream register bus.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_ channel is one 32-bit register access: a read
//   or write at a byte offset, plus the nested_active flag. Every access
//   gives exactly one transaction on the m_ channel with the read data
//   (zero for writes and unmapped offsets) and the maintenance interrupt
//   level as seen after the access.
//   The cfg_ channel sets the number of implemented list registers; it is
//   always ready and must be written only while the block is idle, which
//   the block does not enforce. An access passes the input register, then
//   the result register, to m_tvalid; one access per cycle while m_tready
//   is high. State is updated at acceptance, the list register memory read
//   is registered, and the status maps come from per-entry flag flip-flops.
//   Reset clears HCR, VMCR and APR, sets the list register count to 4 and
//   clears the per-entry valid bits, so every list register reads zero.
//   When m_tready is low the result register holds, the input register
//   behind it fills, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module gic_virtual_interface_control_regs #(
    parameter int MAX_LIST_REGS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config: lr_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gich_pkg::LR_COUNT_W-1:0] cfg_data,
    // s_tdata: op[0], addr[12:1], wdata[44:13], nested_active[45], pad
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gich_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: rdata[31:0], maint_irq[32], pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gich_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (MAX_LIST_REGS > 1) ? $clog2(MAX_LIST_REGS) : 1;
    localparam int CW    = gich_pkg::LR_COUNT_W;
    localparam int DW    = gich_pkg::DATA_W;
    localparam int AW    = gich_pkg::ADDR_W;

    // input unpack
    logic          in_op;
    logic [AW-1:0] in_addr;
    logic [DW-1:0] in_wdata;
    logic          in_nested;
    logic          in_accept;
    logic          in_lr_hit;
    logic [IDX_W-1:0] in_idx;

    assign in_op     = s_tdata[0];
    assign in_addr   = s_tdata[12:1];
    assign in_wdata  = s_tdata[44:13];
    assign in_nested = s_tdata[45];

    // list register decode: aligned, in the LR page, index below the depth
    assign in_lr_hit = (in_addr[1:0] == 2'b00) &&
                       (in_addr[11:8] == gich_pkg::LR_PAGE) &&
                       ({1'b0, in_addr[7:2]} < CW'(MAX_LIST_REGS));
    assign in_idx    = in_addr[IDX_W+1:2];

    // state registers
    logic [CW-1:0]            lr_count_reg;
    logic [DW-1:0]            hcr_reg;
    logic [DW-1:0]            vmcr_reg;
    logic [DW-1:0]            apr_reg;
    logic [MAX_LIST_REGS-1:0] lr_valid_reg;
    logic [MAX_LIST_REGS-1:0] eoi_flag_reg;
    logic [MAX_LIST_REGS-1:0] empty_flag_reg;
    logic [DW-1:0]            lr_mem [MAX_LIST_REGS];

    // input stage
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_nested_reg;
    logic          s1_lr_hit_reg;
    logic          s1_lr_vld_reg;
    logic [DW-1:0] s1_lr_data_reg;

    // result stage
    logic                           m_valid_reg;
    logic [gich_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [gich_pkg::M_TDATA_W-1:0] m_data_next;

    logic advance;

    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_count_reg <= gich_pkg::LR_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            lr_count_reg <= cfg_data;
        end
    end

    // scalar registers and per-entry status flags, updated at acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcr_reg        <= '0;
            vmcr_reg       <= '0;
            apr_reg        <= '0;
            lr_valid_reg   <= '0;
            eoi_flag_reg   <= '0;
            empty_flag_reg <= '1;
        end else if (in_accept && in_op == gich_pkg::OP_WRITE) begin
            if (in_addr == gich_pkg::OFF_HCR) begin
                hcr_reg <= in_wdata;
            end
            if (in_addr == gich_pkg::OFF_VMCR) begin
                vmcr_reg <= in_wdata;
            end
            if (in_addr == gich_pkg::OFF_APR) begin
                apr_reg <= in_wdata;
            end
            if (in_lr_hit) begin
                lr_valid_reg[in_idx]   <= 1'b1;
                empty_flag_reg[in_idx] <=
                    (in_wdata[gich_pkg::LR_STATE_HI:gich_pkg::LR_STATE_LO] == 2'b00);
                eoi_flag_reg[in_idx]   <=
                    (in_wdata[gich_pkg::LR_STATE_HI:gich_pkg::LR_STATE_LO] == 2'b00) &&
                    !in_wdata[gich_pkg::LR_HW_BIT] && in_wdata[gich_pkg::LR_EOI_BIT];
            end
        end
    end

    // list register memory, registered read
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (in_op == gich_pkg::OP_WRITE && in_lr_hit) begin
                lr_mem[in_idx] <= in_wdata;
            end
            s1_lr_data_reg <= lr_mem[in_idx];
        end
    end

    // input stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_op_reg     <= in_op;
            s1_addr_reg   <= in_addr;
            s1_nested_reg <= in_nested;
            s1_lr_hit_reg <= in_lr_hit;
            s1_lr_vld_reg <= lr_valid_reg[in_idx];
        end
    end

    // derived status
    logic [CW-1:0]                lr_eff;
    logic [MAX_LIST_REGS-1:0]     lr_mask;
    logic [MAX_LIST_REGS-1:0]     used_map;
    logic [gich_pkg::STATUS_W-1:0] eoi_map;
    logic [gich_pkg::STATUS_W-1:0] empty_map;
    logic                          underflow;
    logic [DW-1:0]                 misr;
    logic [DW-1:0]                 vtr;
    logic                          maint;
    logic [DW-1:0]                 rdata;

    always_comb begin
        if (lr_count_reg == '0) begin
            lr_eff = CW'(1);
        end else if (lr_count_reg > CW'(MAX_LIST_REGS)) begin
            lr_eff = CW'(MAX_LIST_REGS);
        end else begin
            lr_eff = lr_count_reg;
        end
        for (int i = 0; i < MAX_LIST_REGS; i++) begin
            lr_mask[i] = (CW'(i) < lr_eff);
        end
    end

    assign eoi_map   = gich_pkg::STATUS_W'(eoi_flag_reg & lr_mask);
    assign empty_map = gich_pkg::STATUS_W'(empty_flag_reg & lr_mask);
    assign used_map  = ~empty_flag_reg & lr_mask;
    // at most one in use: clearing the lowest set bit leaves nothing
    assign underflow = hcr_reg[gich_pkg::HCR_UIE_BIT] &&
                       ((used_map & (used_map - 1'b1)) == '0);
    assign misr      = {30'd0, underflow, (eoi_map != '0)};
    assign vtr       = {gich_pkg::VTR_PRI_BITS, gich_pkg::VTR_PRE_BITS, 20'd0,
                        gich_pkg::VTR_CNT_W'(lr_eff - 1'b1)};
    assign maint     = s1_nested_reg && hcr_reg[gich_pkg::HCR_EN_BIT] && (misr != '0);

    // read data select
    always_comb begin
        rdata = '0;
        if (s1_op_reg == gich_pkg::OP_READ) begin
            unique case (s1_addr_reg)
                gich_pkg::OFF_HCR:    rdata = hcr_reg;
                gich_pkg::OFF_VTR:    rdata = vtr;
                gich_pkg::OFF_VMCR:   rdata = vmcr_reg;
                gich_pkg::OFF_MISR:   rdata = misr;
                gich_pkg::OFF_EISR0:  rdata = eoi_map[31:0];
                gich_pkg::OFF_EISR1:  rdata = eoi_map[63:32];
                gich_pkg::OFF_ELRSR0: rdata = empty_map[31:0];
                gich_pkg::OFF_ELRSR1: rdata = empty_map[63:32];
                gich_pkg::OFF_APR:    rdata = apr_reg;
                default: begin
                    if (s1_lr_hit_reg && s1_lr_vld_reg) begin
                        rdata = s1_lr_data_reg;
                    end
                end
            endcase
        end
    end

    assign m_data_next = {7'd0, maint, rdata};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
